### sv/tgd_pkg.sv
// Shared types, constants and the CORDIC angle table for the tilt gesture detector.
`default_nettype none

package tgd_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned ACCEL_BITS_DEF   = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF    = 32;

  // Fixed field widths.
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned ANGLE_W = 17;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;

  // Angle accumulator: degrees with 16 fraction bits.
  localparam int unsigned ZW          = 26;
  localparam int          DEG180_Z    = 180 * 65536;
  localparam int          ANGLE_LIMIT = 46080;

  // Register reset values.
  localparam logic [CFG_W-1:0] TRIGGER_RST  = 16'd5120;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd2560;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd300;
  localparam logic [CFG_W-1:0] COOLDOWN_RST = 16'd800;

  typedef enum logic [IDX_W-1:0] {
    CFG_TRIGGER  = 3'd0,
    CFG_RELEASE  = 3'd1,
    CFG_HOLD     = 3'd2,
    CFG_COOLDOWN = 3'd3,
    CFG_UPRIGHT  = 3'd4,
    CFG_INVERT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GS_FLAT  = 2'd0,
    GS_LEFT  = 2'd1,
    GS_RIGHT = 2'd2
  } gesture_e;

  typedef enum logic [1:0] {
    FE_IDLE   = 2'd0,
    FE_SQUARE = 2'd1,
    FE_SUM    = 2'd2,
    FE_PUSH   = 2'd3
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ITER  = 2'd1,
    BK_ROUND = 2'd2,
    BK_DONE  = 2'd3
  } back_state_e;

  // Status of one result transaction.
  typedef struct packed {
    logic       left_event;
    logic       right_event;
    logic       evaluated;
    logic [1:0] tilt_state;
  } tgd_flags_t;

  // atan(2^-i) in degrees with 16 fraction bits, rounded.
  function automatic logic [21:0] tgd_atan(input logic [4:0] idx);
    logic [21:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### sv/tgd_fifo.sv
// Two-entry queue between the filter front end and the CORDIC back end.
`default_nettype none

module tgd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/tgd_front.sv
// Front end: sample acceptance, low-pass filter, magnitude gate and CORDIC operand choice.
`default_nettype none

module tgd_front #(
  parameter int unsigned ACCEL_BITS = 16,
  parameter int unsigned TIME_BITS  = 32,
  localparam int unsigned CW        = ACCEL_BITS + 3,
  localparam int unsigned EW        = TIME_BITS + 2 * CW + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_valid_i,
  output logic                              s_ready_o,
  input  wire logic signed [ACCEL_BITS-1:0] accel_x_i,
  input  wire logic signed [ACCEL_BITS-1:0] accel_y_i,
  input  wire logic signed [ACCEL_BITS-1:0] accel_z_i,
  input  wire logic [TIME_BITS-1:0]         now_i,
  input  wire logic                         upright_i,
  output logic                              push_o,
  output logic [EW-1:0]                     push_data_o,
  input  wire logic                         full_i
);

  import tgd_pkg::*;

  localparam int unsigned FW  = ACCEL_BITS + 2;
  localparam int unsigned SQW = 2 * FW;
  localparam int unsigned M2W = SQW + 2;
  localparam int unsigned HW  = M2W + 5;
  localparam int unsigned AF  = ACCEL_BITS - 4;
  localparam logic [M2W-1:0] GATE_LO = M2W'(1) << (2 * AF - 2);
  localparam logic [HW-1:0]  GATE_HI = HW'(1) << (2 * AF + 6);

  front_state_e state_q, state_d;

  logic                    loaded_q, chk_q;
  logic signed [FW-1:0]    fx_q, fy_q, fz_q;
  logic signed [FW-1:0]    fx_upd, fy_upd, fz_upd;
  logic signed [FW:0]      dx, dy, dz;
  logic signed [SQW-1:0]   sqx_q, sqy_q, sqz_q;
  logic [M2W-1:0]          m2_q;
  logic [HW-1:0]           m2_25;
  logic [TIME_BITS-1:0]    now_q;
  logic                    accept, pass;
  logic signed [CW-1:0]    op_y, op_x;

  assign accept = s_valid_i && s_ready_o;

  // f += (a - f) >>> 2, rounding toward minus infinity.
  assign dx     = (FW + 1)'(accel_x_i) - (FW + 1)'(fx_q);
  assign dy     = (FW + 1)'(accel_y_i) - (FW + 1)'(fy_q);
  assign dz     = (FW + 1)'(accel_z_i) - (FW + 1)'(fz_q);
  assign fx_upd = fx_q + FW'(dx >>> 2);
  assign fy_upd = fy_q + FW'(dy >>> 2);
  assign fz_upd = fz_q + FW'(dz >>> 2);

  // 25 * m2 as shifts and adds against the upper gate of 2.56 g squared.
  assign m2_25 = (HW'(m2_q) << 4) + (HW'(m2_q) << 3) + HW'(m2_q);
  assign pass  = chk_q && (m2_q >= GATE_LO) && (m2_25 <= GATE_HI);

  assign op_y = upright_i ? CW'(fz_q) : CW'(fx_q);
  assign op_x = upright_i ? -CW'(fy_q) : CW'(fz_q);

  assign push_data_o = {now_q, op_x, op_y, pass};

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    push_o    = 1'b0;
    case (state_q)
      FE_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          state_d = loaded_q ? FE_SQUARE : FE_PUSH;
        end
      end
      FE_SQUARE: state_d = FE_SUM;
      FE_SUM:    state_d = FE_PUSH;
      FE_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FE_IDLE;
      loaded_q <= 1'b0;
      chk_q    <= 1'b0;
      fx_q     <= '0;
      fy_q     <= '0;
      fz_q     <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        loaded_q <= 1'b1;
        chk_q    <= loaded_q;
        if (loaded_q) begin
          fx_q <= fx_upd;
          fy_q <= fy_upd;
          fz_q <= fz_upd;
        end else begin
          fx_q <= FW'(accel_x_i);
          fy_q <= FW'(accel_y_i);
          fz_q <= FW'(accel_z_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_i;
    end
    if (state_q == FE_SQUARE) begin
      sqx_q <= fx_q * fx_q;
      sqy_q <= fy_q * fy_q;
      sqz_q <= fz_q * fz_q;
    end
    if (state_q == FE_SUM) begin
      m2_q <= M2W'($unsigned(sqx_q)) + M2W'($unsigned(sqy_q)) + M2W'($unsigned(sqz_q));
    end
  end

endmodule

`default_nettype wire

### sv/tgd_back.sv
// Back end: iterative CORDIC atan2, angle rounding and the gesture hysteresis machine.
`default_nettype none

module tgd_back #(
  parameter int unsigned ACCEL_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned TIME_BITS    = 32,
  localparam int unsigned CW          = ACCEL_BITS + 3,
  localparam int unsigned EW          = TIME_BITS + 2 * CW + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [EW-1:0]              entry_i,
  input  wire logic                       empty_i,
  output logic                            pop_o,
  input  wire logic [tgd_pkg::CFG_W-1:0]  trigger_i,
  input  wire logic [tgd_pkg::CFG_W-1:0]  release_i,
  input  wire logic [tgd_pkg::CFG_W-1:0]  hold_i,
  input  wire logic [tgd_pkg::CFG_W-1:0]  cooldown_i,
  input  wire logic                       invert_i,
  output logic                            m_valid_o,
  input  wire logic                       m_ready_i,
  output tgd_pkg::tgd_flags_t             m_flags_o,
  output logic signed [tgd_pkg::ANGLE_W-1:0] m_angle_o
);

  import tgd_pkg::*;

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
  localparam int unsigned CMP_W = ANGLE_W + 1;

  back_state_e state_q, state_d;

  logic                     eval_q;
  logic [TIME_BITS-1:0]     now_q;
  logic signed [CW-1:0]     x_q, y_q, xs, ys, e_x, e_y;
  logic signed [ZW-1:0]     z_q, at, zr, zc;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [ANGLE_W-1:0] ang_q, ang_d;

  gesture_e                 gs_q, gs_d;
  logic [TIME_BITS-1:0]     start_q, start_d, cdend_q, cdend_d;
  logic                     left_d, right_d;

  logic                     out_valid_q, out_load;
  tgd_flags_t               out_flags_q;
  logic signed [ANGLE_W-1:0] out_angle_q;

  logic signed [CMP_W-1:0]  a18, pos_rel, neg_rel, pos_trig, neg_trig;
  logic                     is_left, back_in, held;
  logic [TIME_BITS-1:0]     elapsed;

  assign e_y = entry_i[CW:1];
  assign e_x = entry_i[2*CW:CW+1];

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = ZW'(tgd_atan(5'(cnt_q)));

  // Round to Q8.8, clamp, then apply the optional sign flip.
  assign zr = (z_q + ZW'(128)) >>> 8;
  always_comb begin
    if (zr > ZW'(ANGLE_LIMIT)) begin
      zc = ZW'(ANGLE_LIMIT);
    end else if (zr < -ZW'(ANGLE_LIMIT)) begin
      zc = -ZW'(ANGLE_LIMIT);
    end else begin
      zc = zr;
    end
  end
  assign ang_d = invert_i ? -ANGLE_W'(zc) : ANGLE_W'(zc);

  assign a18      = CMP_W'(ang_q);
  assign pos_rel  = CMP_W'(release_i);
  assign neg_rel  = -CMP_W'(release_i);
  assign pos_trig = CMP_W'(trigger_i);
  assign neg_trig = -CMP_W'(trigger_i);
  assign is_left  = (gs_q == GS_LEFT);
  assign back_in  = is_left ? (a18 > neg_rel) : (a18 < pos_rel);
  assign elapsed  = now_q - start_q;
  assign held     = (elapsed >= TIME_BITS'(hold_i));

  assign out_load = (state_q == BK_DONE) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    gs_d    = gs_q;
    start_d = start_q;
    cdend_d = cdend_q;
    left_d  = 1'b0;
    right_d = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = entry_i[0] ? BK_ITER : BK_DONE;
        end
      end
      BK_ITER: begin
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = BK_ROUND;
        end
      end
      BK_ROUND: state_d = BK_DONE;
      BK_DONE: begin
        if (out_load) begin
          state_d = BK_IDLE;
        end
        if (eval_q) begin
          case (gs_q)
            GS_LEFT, GS_RIGHT: begin
              if (back_in) begin
                gs_d = GS_FLAT;
              end else if (held) begin
                gs_d = GS_FLAT;
                // A hold that completes inside the cooldown window is dropped silently.
                if (now_q >= cdend_q) begin
                  left_d  = is_left;
                  right_d = !is_left;
                  cdend_d = now_q + TIME_BITS'(cooldown_i);
                end
              end
            end
            default: begin
              gs_d = GS_FLAT;
              if (a18 < neg_trig) begin
                gs_d    = GS_LEFT;
                start_d = now_q;
              end else if (a18 > pos_trig) begin
                gs_d    = GS_RIGHT;
                start_d = now_q;
              end
            end
          endcase
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      gs_q        <= GS_FLAT;
      start_q     <= '0;
      cdend_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        gs_q        <= gs_d;
        start_q     <= start_d;
        cdend_q     <= cdend_d;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        eval_q <= entry_i[0];
        now_q  <= entry_i[EW-1:2*CW+1];
        cnt_q  <= '0;
        ang_q  <= '0;
        // A vector in the left half-plane is first turned by 180 degrees.
        if (e_x < 0) begin
          x_q <= -e_x;
          y_q <= -e_y;
          z_q <= (e_y >= 0) ? ZW'(DEG180_Z) : -ZW'(DEG180_Z);
        end else begin
          x_q <= e_x;
          y_q <= e_y;
          z_q <= '0;
        end
      end
      BK_ITER: begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (y_q < 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      BK_ROUND: ang_q <= ang_d;
      default: ;
    endcase
    if (out_load) begin
      out_flags_q.left_event  <= left_d;
      out_flags_q.right_event <= right_d;
      out_flags_q.evaluated   <= eval_q;
      out_flags_q.tilt_state  <= gs_d;
      out_angle_q             <= ang_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_flags_o = out_flags_q;
  assign m_angle_o = out_angle_q;

`ifndef SYNTHESIS
  a_event_only_evaluated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (left_d || right_d) |-> eval_q && (gs_d == GS_FLAT))
    else $error("gesture event on an unevaluated sample or without return to flat");

  a_single_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(left_d && right_d))
    else $error("left and right gestures in the same transaction");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_ITER |-> cnt_q <= CNT_W'(CORDIC_STEPS - 1))
    else $error("CORDIC step counter ran past the last step");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> state_q == BK_IDLE && out_valid_q)
    else $error("result register load did not release the back end");
`endif

endmodule

`default_nettype wire

### sv/tilt_gesture_detector.sv
// Top level of the tilt gesture detector: ports, configuration registers and the two halves.
//
// Each sample transaction yields exactly one result transaction. The front end takes a sample
// only once the last one is pushed into the queue, which stalls it while full; the first
// sample after reset only loads the filter. The back end takes an evaluated sample through
// idle, the CORDIC steps of the single shared rotator doing one step a cycle, rounding and
// done, and a skipped one through idle and done. A two-entry queue between the halves and
// the result register let either side stall without stopping the other. Configuration writes
// take effect at once; the user must make them only while no sample is in flight, unchecked.
`default_nettype none

module tilt_gesture_detector #(
  parameter int unsigned ACCEL_BITS   = tgd_pkg::ACCEL_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = tgd_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned TIME_BITS    = tgd_pkg::TIME_BITS_DEF,
  localparam int unsigned IN_W        = 3 * ACCEL_BITS + tgd_pkg::NOW_W,
  localparam int unsigned IN_TW       = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_TW      = 24
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // accel_x, accel_y, accel_z, now_ms from the lowest bit up, zero padded
  input  wire logic [IN_TW-1:0]          s_axis_tdata,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // left_event, right_event, evaluated, tilt_angle, tilt_state from the lowest bit up
  output logic [OUT_TW-1:0]              m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  input  wire logic                      cfg_we_i,
  input  wire logic [tgd_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [tgd_pkg::CFG_W-1:0] cfg_data_i
);

  import tgd_pkg::*;

  localparam int unsigned CW = ACCEL_BITS + 3;
  localparam int unsigned EW = TIME_BITS + 2 * CW + 1;

  logic [CFG_W-1:0] trigger_q, release_q, hold_q, cooldown_q;
  logic             upright_q, invert_q;

  logic             push, pop, full, empty;
  logic [EW-1:0]    push_data, pop_data;
  tgd_flags_t       flags;
  logic signed [ANGLE_W-1:0] angle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q  <= TRIGGER_RST;
      release_q  <= RELEASE_RST;
      hold_q     <= HOLD_RST;
      cooldown_q <= COOLDOWN_RST;
      upright_q  <= 1'b0;
      invert_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TRIGGER:  trigger_q  <= cfg_data_i;
        CFG_RELEASE:  release_q  <= cfg_data_i;
        CFG_HOLD:     hold_q     <= cfg_data_i;
        CFG_COOLDOWN: cooldown_q <= cfg_data_i;
        CFG_UPRIGHT:  upright_q  <= cfg_data_i[0];
        CFG_INVERT:   invert_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tgd_front #(
    .ACCEL_BITS (ACCEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .accel_x_i   (s_axis_tdata[ACCEL_BITS-1:0]),
    .accel_y_i   (s_axis_tdata[2*ACCEL_BITS-1:ACCEL_BITS]),
    .accel_z_i   (s_axis_tdata[3*ACCEL_BITS-1:2*ACCEL_BITS]),
    .now_i       (s_axis_tdata[3*ACCEL_BITS+TIME_BITS-1:3*ACCEL_BITS]),
    .upright_i   (upright_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  tgd_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  tgd_back #(
    .ACCEL_BITS   (ACCEL_BITS),
    .CORDIC_STEPS (CORDIC_STEPS),
    .TIME_BITS    (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .trigger_i  (trigger_q),
    .release_i  (release_q),
    .hold_i     (hold_q),
    .cooldown_i (cooldown_q),
    .invert_i   (invert_q),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_flags_o  (flags),
    .m_angle_o  (angle)
  );

  assign m_axis_tdata = {2'b00, flags.tilt_state, angle,
                         flags.evaluated, flags.right_event, flags.left_event};

endmodule

`default_nettype wire
